// ===== rtl/validated_transaction_store_top_defines.svh =====
// Assertion macros used by the asserting module of the transaction store.
`ifndef VALIDATED_TRANSACTION_STORE_TOP_DEFINES_SVH
`define VALIDATED_TRANSACTION_STORE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/vts_pkg.sv =====
package vts_pkg;

    // Field widths of the stream items.
    localparam int CMD_BITS      = 2;
    localparam int KEY_BITS      = 10;
    localparam int VALUE_BITS    = 64;
    localparam int KIND_BITS     = 2;
    localparam int IN_DATA_BITS  = 80;
    localparam int OUT_DATA_BITS = 80;

    // Store geometry: one entry for every key value.
    localparam int KEY_COUNT = 1 << KEY_BITS;
    localparam int ADDR_BITS = KEY_BITS;

    // Operation buffer geometry.
    localparam int MAX_OPS   = 16;
    localparam int CNT_BITS  = $clog2(MAX_OPS + 1);
    localparam int IDX_BITS  = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int PEND_BITS = VALUE_BITS + KEY_BITS + CMD_BITS;

    // Operation codes.
    localparam logic [CMD_BITS-1:0] CMD_CHECK  = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd2;
    localparam logic [CMD_BITS-1:0] CMD_IGNORE = 2'd3;

    // Result kinds.
    localparam logic [KIND_BITS-1:0] KIND_VALUE   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_UPDATED = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_STATUS  = 2'd2;

    // One buffered operation.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [KEY_BITS-1:0]   key;
        logic [CMD_BITS-1:0]   cmd;
    } pend_entry_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_V_RDP,
        ST_V_RDM,
        ST_V_CMP,
        ST_A_RDP,
        ST_A_RDM,
        ST_A_RD,
        ST_STATUS
    } state_t;

endpackage

// ===== rtl/vts_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module vts_ram #(
    parameter int  DEPTH = 16,
    parameter int  WIDTH = 8,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/validated_transaction_store_top.sv =====
// Transactional key-value store with multi-key compare-and-swap. Operations of a transaction
// arrive one per input transfer and are buffered at one per cycle, up to MAX_OPS; further
// operations are dropped. The transfer marked tlast starts a validation pass over the buffer,
// whose mismatches are returned, then, if nothing mismatched, an apply pass that writes and
// echoes writes and returns reads, and finally one status transfer. Input is not accepted
// during the passes, nor while the status transfer waits on a stalled output. After reset,
// and after a first operation that carries clear_store, a clearing pass writes zero to every
// store entry (KEY_COUNT, 1024), one per cycle, while no input is accepted. All arithmetic
// runs through one value comparator and the single read port of each memory.
`include "validated_transaction_store_top_defines.svh"

module validated_transaction_store_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: command[1:0], key[11:2], value[75:12], zero padding[79:76].
    input  logic [vts_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // Fields from bit 0: clear_store[0].
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: result_key[9:0], result_value[73:10], aborted[74], zero padding[79:75].
    output logic [vts_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // Fields from bit 0: result_kind[1:0].
    output logic [vts_pkg::KIND_BITS-1:0]       m_axis_tuser,
    output logic                                m_axis_tlast
);

    localparam int KB = vts_pkg::KEY_BITS;
    localparam int VB = vts_pkg::VALUE_BITS;
    localparam int CB = vts_pkg::CMD_BITS;

    vts_pkg::state_t state_reg, state_next;
    logic [vts_pkg::CNT_BITS-1:0]  count_reg, count_next;
    logic [vts_pkg::CNT_BITS-1:0]  idx_reg, idx_next, idx_inc;
    logic [vts_pkg::ADDR_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic                          bad_reg, bad_next;
    logic                          last_reg, last_next;

    logic                          out_valid_reg, out_valid_next;
    logic [vts_pkg::KIND_BITS-1:0] out_kind_reg, out_kind_next;
    logic [KB-1:0]                 out_key_reg, out_key_next;
    logic [VB-1:0]                 out_value_reg, out_value_next;
    logic                          out_aborted_reg, out_aborted_next;
    logic                          out_last_reg, out_last_next;

    logic                  in_accept;
    logic                  slot_free;
    logic                  load_out;
    logic                  last_step;
    logic                  mismatch;
    vts_pkg::pend_entry_t  in_entry;
    vts_pkg::pend_entry_t  pend_q;

    logic                          pend_wr_en;
    logic                          pend_rd_en;
    logic [vts_pkg::PEND_BITS-1:0] pend_rd_data;
    logic                          mem_wr_en;
    logic [vts_pkg::ADDR_BITS-1:0] mem_wr_addr;
    logic [VB-1:0]                 mem_wr_data;
    logic                          mem_rd_en;
    logic [VB-1:0]                 mem_rd_data;

    // Unpack the incoming operation.
    assign in_entry.cmd   = s_axis_tdata[CB-1:0];
    assign in_entry.key   = s_axis_tdata[CB+KB-1:CB];
    assign in_entry.value = s_axis_tdata[CB+KB+VB-1:CB+KB];

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign slot_free = !out_valid_reg || m_axis_tready;
    assign pend_q    = vts_pkg::pend_entry_t'(pend_rd_data);
    assign idx_inc   = idx_reg + 1'b1;
    assign last_step = (idx_inc == count_reg);

    // The single comparator: stored value against the expected value of a check.
    assign mismatch = (mem_rd_data != pend_q.value);

    // Operation buffer.
    vts_ram #(
        .DEPTH (vts_pkg::MAX_OPS),
        .WIDTH (vts_pkg::PEND_BITS)
    ) u_pend_ram (
        .clk     (clk),
        .wr_en   (pend_wr_en),
        .wr_addr (count_reg[vts_pkg::IDX_BITS-1:0]),
        .wr_data (in_entry),
        .rd_en   (pend_rd_en),
        .rd_addr (idx_reg[vts_pkg::IDX_BITS-1:0]),
        .rd_data (pend_rd_data)
    );

    // Value store, read at the key of the buffered operation in hand.
    vts_ram #(
        .DEPTH (vts_pkg::KEY_COUNT),
        .WIDTH (VB)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (pend_q.key),
        .rd_data (mem_rd_data)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vts_pkg::ST_CLEAR;
            count_reg     <= '0;
            idx_reg       <= '0;
            clr_addr_reg  <= '0;
            bad_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            clr_addr_reg  <= clr_addr_next;
            bad_reg       <= bad_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        out_kind_reg    <= out_kind_next;
        out_key_reg     <= out_key_next;
        out_value_reg   <= out_value_next;
        out_aborted_reg <= out_aborted_next;
        out_last_reg    <= out_last_next;
    end

    // Sequencer: buffering, clearing, validation pass, apply pass and status.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        clr_addr_next    = clr_addr_reg;
        bad_next         = bad_reg;
        last_next        = last_reg;
        load_out         = 1'b0;
        out_kind_next    = out_kind_reg;
        out_key_next     = out_key_reg;
        out_value_next   = out_value_reg;
        out_aborted_next = out_aborted_reg;
        out_last_next    = out_last_reg;
        s_axis_tready    = 1'b0;
        pend_wr_en       = 1'b0;
        pend_rd_en       = 1'b0;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = pend_q.key;
        mem_wr_data      = pend_q.value;
        mem_rd_en        = 1'b0;

        unique case (state_reg)
            vts_pkg::ST_CLEAR:
            begin
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                mem_wr_data   = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == vts_pkg::ADDR_BITS'(vts_pkg::KEY_COUNT - 1))
                begin
                    clr_addr_next = '0;
                    idx_next      = '0;
                    state_next    = last_reg ? vts_pkg::ST_V_RDP : vts_pkg::ST_IDLE;
                end
            end

            vts_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (in_accept)
                begin
                    last_next = s_axis_tlast;
                    idx_next  = '0;
                    if (count_reg < vts_pkg::CNT_BITS'(vts_pkg::MAX_OPS))
                    begin
                        pend_wr_en = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if ((count_reg == '0) && s_axis_tuser)
                    begin
                        state_next = vts_pkg::ST_CLEAR;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = vts_pkg::ST_V_RDP;
                    end
                end
            end

            vts_pkg::ST_V_RDP:
            begin
                pend_rd_en = 1'b1;
                state_next = vts_pkg::ST_V_RDM;
            end

            vts_pkg::ST_V_RDM:
            begin
                if (pend_q.cmd == vts_pkg::CMD_CHECK)
                begin
                    mem_rd_en  = 1'b1;
                    state_next = vts_pkg::ST_V_CMP;
                end
                else
                begin
                    idx_next = idx_inc;
                    if (last_step)
                    begin
                        idx_next   = '0;
                        state_next = bad_reg ? vts_pkg::ST_STATUS : vts_pkg::ST_A_RDP;
                    end
                    else
                    begin
                        state_next = vts_pkg::ST_V_RDP;
                    end
                end
            end

            vts_pkg::ST_V_CMP:
            begin
                if (!mismatch || slot_free)
                begin
                    if (mismatch)
                    begin
                        load_out         = 1'b1;
                        out_kind_next    = vts_pkg::KIND_VALUE;
                        out_key_next     = pend_q.key;
                        out_value_next   = mem_rd_data;
                        out_aborted_next = 1'b0;
                        out_last_next    = 1'b0;
                        bad_next         = 1'b1;
                    end
                    idx_next = idx_inc;
                    if (last_step)
                    begin
                        idx_next   = '0;
                        state_next = (bad_reg || mismatch) ? vts_pkg::ST_STATUS
                                                           : vts_pkg::ST_A_RDP;
                    end
                    else
                    begin
                        state_next = vts_pkg::ST_V_RDP;
                    end
                end
            end

            vts_pkg::ST_A_RDP:
            begin
                pend_rd_en = 1'b1;
                state_next = vts_pkg::ST_A_RDM;
            end

            vts_pkg::ST_A_RDM:
            begin
                case (pend_q.cmd)
                    vts_pkg::CMD_WRITE:
                    begin
                        if (slot_free)
                        begin
                            mem_wr_en        = 1'b1;
                            load_out         = 1'b1;
                            out_kind_next    = vts_pkg::KIND_UPDATED;
                            out_key_next     = pend_q.key;
                            out_value_next   = pend_q.value;
                            out_aborted_next = 1'b0;
                            out_last_next    = 1'b0;
                            idx_next         = idx_inc;
                            state_next       = last_step ? vts_pkg::ST_STATUS
                                                         : vts_pkg::ST_A_RDP;
                        end
                    end
                    vts_pkg::CMD_READ:
                    begin
                        mem_rd_en  = 1'b1;
                        state_next = vts_pkg::ST_A_RD;
                    end
                    default:
                    begin
                        idx_next   = idx_inc;
                        state_next = last_step ? vts_pkg::ST_STATUS : vts_pkg::ST_A_RDP;
                    end
                endcase
            end

            vts_pkg::ST_A_RD:
            begin
                if (slot_free)
                begin
                    load_out         = 1'b1;
                    out_kind_next    = vts_pkg::KIND_VALUE;
                    out_key_next     = pend_q.key;
                    out_value_next   = mem_rd_data;
                    out_aborted_next = 1'b0;
                    out_last_next    = 1'b0;
                    idx_next         = idx_inc;
                    state_next       = last_step ? vts_pkg::ST_STATUS : vts_pkg::ST_A_RDP;
                end
            end

            vts_pkg::ST_STATUS:
            begin
                if (slot_free)
                begin
                    load_out         = 1'b1;
                    out_kind_next    = vts_pkg::KIND_STATUS;
                    out_key_next     = '0;
                    out_value_next   = '0;
                    out_aborted_next = bad_reg;
                    out_last_next    = 1'b1;
                    count_next       = '0;
                    idx_next         = '0;
                    bad_next         = 1'b0;
                    last_next        = 1'b0;
                    state_next       = vts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = vts_pkg::ST_IDLE;
            end
        endcase

        // Output register valid flag.
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Pack the result transfer.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(vts_pkg::OUT_DATA_BITS - KB - VB - 1){1'b0}},
                            out_aborted_reg, out_value_reg, out_key_reg};

    // Checks on the sequencer.
    `VTS_ASSERT_NOW(a_count_bound, 1'b1,
        count_reg <= vts_pkg::CNT_BITS'(vts_pkg::MAX_OPS), "buffer count exceeds its depth")
    `VTS_ASSERT_NEXT(a_out_hold, out_valid_reg && !m_axis_tready,
        out_valid_reg && $stable(out_kind_reg) && $stable(out_key_reg)
        && $stable(out_value_reg), "stalled result changed")
    `VTS_ASSERT_NEXT(a_status_ends, (state_reg == vts_pkg::ST_STATUS) && slot_free,
        (count_reg == '0) && !bad_reg && (state_reg == vts_pkg::ST_IDLE),
        "transaction state not cleared after status")
    `VTS_ASSERT_NOW(a_last_is_status, out_valid_reg && out_last_reg,
        out_kind_reg == vts_pkg::KIND_STATUS, "last result is not a status item")

endmodule
